// ===== hdl/windowed_frame_rate_meter_defines.svh =====
// Assertion helpers used by the frame rate meter module.
// Every macro samples on aclk and is disabled while aresetn is low.
`ifndef WINDOWED_FRAME_RATE_METER_DEFINES_SVH
`define WINDOWED_FRAME_RATE_METER_DEFINES_SVH

// Same-cycle implication between two conditions.
`define WFRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Implication into the following cycle.
`define WFRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/wfrm_pkg.sv =====
`default_nettype none

package wfrm_pkg;

    // Default depth of the delay ring.
    localparam int WINDOW_DEF = 16;

    // Fixed field widths.
    localparam int TICK_W  = 32;
    localparam int DELAY_W = 16;
    localparam int RATE_W  = 26;
    localparam int FRAMES_W = 9;

    // Largest stored delay in milliseconds.
    localparam logic [DELAY_W-1:0] DELAY_MAX = 16'hFFFF;

    // 1000 frames per second scaled by 256 for the fraction bits.
    localparam logic [RATE_W-1:0] FRAME_SCALE = 26'd256000;

    // Saturated rate reported for a zero delay sum.
    localparam logic [RATE_W-1:0] RATE_SAT = 26'd65536000;

    // Request kinds carried on the input tuser bit.
    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_FRAME = 1'b1;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/windowed_frame_rate_meter.sv =====
// Windowed frame rate meter.
//
// The input stream carries one request per event: tuser bit 0 is the kind
// (0 starts a new measurement and clears the window, 1 marks a finished
// frame) and tdata holds the 32-bit millisecond timestamp. Every request
// produces exactly one result on the output stream: the rate in frames per
// second with 8 fraction bits, the number of delays averaged, and a flag
// set when the summed delay was zero and the rate saturated.
//
// A start request goes straight to the finish step. A frame request passes
// through the update of the running sum, the launch of the serial divider,
// the divide step in which the divider forms the quotient bits, the take of
// the quotient and the load of the output register. A frame with a zero
// delay sum skips the divider. The divider serves one frame at a time and
// s_tready is high only while the sequencer is idle.
//
// The finished result sits in an output register. If the receiver stalls,
// the next request is still accepted and processed, and the sequencer holds
// its result until the output register is free. Reset empties the window,
// zeroes the stored timestamp and drops any pending result.

`default_nettype none

`include "windowed_frame_rate_meter_defines.svh"

module windowed_frame_rate_meter #(
    parameter int WINDOW = wfrm_pkg::WINDOW_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] tick_ms
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // [25:0] rate_q8, [34:26] frames_in_window,
                                        // [35] zero_time, [39:36] zero
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);
    localparam int TICK_W  = wfrm_pkg::TICK_W;
    localparam int DELAY_W = wfrm_pkg::DELAY_W;
    localparam int RATE_W  = wfrm_pkg::RATE_W;
    localparam int FRAMES_W = wfrm_pkg::FRAMES_W;

    wfrm_pkg::state_t state_reg, state_next;

    logic [DELAY_W-1:0] ring_mem [WINDOW];

    logic [TICK_W-1:0]  last_stamp_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [CNT_W-1:0]   filled_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic [DELAY_W-1:0] rd_data_reg;
    logic [RATE_W-1:0]  num_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic               zero_reg;
    logic               m_tvalid_reg;
    logic [39:0]        m_tdata_reg;

    logic               s_accept;
    logic               div_start;
    logic               div_done;
    logic [RATE_W-1:0]  div_quotient;
    logic               out_free;
    logic               out_load;
    logic [TICK_W-1:0]  elapsed;
    logic [DELAY_W-1:0] delay_sat;
    logic               old_valid;
    logic [SUM_W-1:0]   old_delay;
    logic [SUM_W-1:0]   sum_upd;
    logic [CNT_W-1:0]   filled_upd;
    logic [SLOT_W-1:0]  slot_upd;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Delay since the previous timestamp, saturated to 16 bits.
    always_comb begin
        elapsed   = s_tdata - last_stamp_reg;
        delay_sat = (|elapsed[TICK_W-1:DELAY_W]) ? wfrm_pkg::DELAY_MAX
                                                 : elapsed[DELAY_W-1:0];
    end

    // Running sum update; entries past the fill count are treated as zero.
    always_comb begin
        old_valid  = (CNT_W'(slot_reg) < filled_reg);
        old_delay  = old_valid ? SUM_W'(rd_data_reg) : '0;
        sum_upd    = sum_reg - old_delay + SUM_W'(delay_reg);
        filled_upd = (filled_reg < CNT_W'(WINDOW)) ? filled_reg + 1'b1 : filled_reg;
        slot_upd   = (slot_reg == SLOT_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
    end

    // Next state of the sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            wfrm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = (s_tuser[0] == wfrm_pkg::ACTION_START)
                               ? wfrm_pkg::ST_FINISH : wfrm_pkg::ST_UPDATE;
                end
            end
            wfrm_pkg::ST_UPDATE: begin
                state_next = (sum_upd == '0) ? wfrm_pkg::ST_FINISH : wfrm_pkg::ST_LAUNCH;
            end
            wfrm_pkg::ST_LAUNCH: begin
                state_next = wfrm_pkg::ST_DIVIDE;
            end
            wfrm_pkg::ST_DIVIDE: begin
                if (div_done) begin
                    state_next = wfrm_pkg::ST_FINISH;
                end
            end
            wfrm_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = wfrm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wfrm_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            wfrm_pkg::ST_IDLE:   s_tready  = 1'b1;
            wfrm_pkg::ST_LAUNCH: div_start = 1'b1;
            wfrm_pkg::ST_FINISH: out_load  = out_free;
            default: begin
            end
        endcase
    end

    // Serial divider for the rate.
    wfrm_divider #(
        .NUM_W (RATE_W),
        .DEN_W (SUM_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_reg),
        .divisor  (sum_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // Delay ring: read at acceptance, written during the update.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= ring_mem[slot_reg];
        end
        if (state_reg == wfrm_pkg::ST_UPDATE) begin
            ring_mem[slot_reg] <= delay_reg;
        end
    end

    // Window state and output register control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= wfrm_pkg::ST_IDLE;
            last_stamp_reg <= '0;
            slot_reg       <= '0;
            filled_reg     <= '0;
            sum_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_accept) begin
                last_stamp_reg <= s_tdata;
                if (s_tuser[0] == wfrm_pkg::ACTION_START) begin
                    slot_reg   <= '0;
                    filled_reg <= '0;
                    sum_reg    <= '0;
                end
            end
            if (state_reg == wfrm_pkg::ST_UPDATE) begin
                slot_reg   <= slot_upd;
                filled_reg <= filled_upd;
                sum_reg    <= sum_upd;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Result datapath.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            delay_reg <= delay_sat;
            rate_reg  <= '0;
            zero_reg  <= 1'b0;
        end
        if (state_reg == wfrm_pkg::ST_UPDATE) begin
            num_reg <= RATE_W'(filled_upd) * wfrm_pkg::FRAME_SCALE;
            if (sum_upd == '0) begin
                rate_reg <= wfrm_pkg::RATE_SAT;
                zero_reg <= 1'b1;
            end
        end
        if ((state_reg == wfrm_pkg::ST_DIVIDE) && div_done) begin
            rate_reg <= div_quotient;
            zero_reg <= 1'b0;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0, zero_reg, FRAMES_W'(filled_reg), rate_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the sequencer and the window bookkeeping.
    `WFRM_ASSERT_NOW(a_fill_bound, 1'b1, filled_reg <= CNT_W'(WINDOW),
        "fill count exceeds the window depth")
    `WFRM_ASSERT_NEXT(a_frame_goes_update,
        s_accept && (s_tuser[0] == wfrm_pkg::ACTION_FRAME),
        state_reg == wfrm_pkg::ST_UPDATE,
        "frame request did not enter the update step")
    `WFRM_ASSERT_NOW(a_zero_saturates, m_tvalid_reg && m_tdata_reg[35],
        m_tdata_reg[25:0] == wfrm_pkg::RATE_SAT,
        "zero delay flag without saturated rate")
    `WFRM_ASSERT_NOW(a_divider_only_when_dividing, div_done,
        state_reg == wfrm_pkg::ST_DIVIDE,
        "divider finished outside the divide step")

endmodule

`default_nettype wire

// ===== hdl/wfrm_divider.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module wfrm_divider #(
    parameter int NUM_W = 26,
    parameter int DEN_W = 20
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic      [NUM_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;

    // One shift-and-subtract step of the partial remainder.
    always_comb begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        take  = (trial >= {1'b0, den_reg});
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(NUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], take};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flags are reset; the datapath is not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire
